FILE: hdl/spectral_peak_finder_defines.svh
// ----------------------------------------------------------------------------
// Spectral peak finder assertion macros
// Shared macros for the concurrent checks on the peak finder ports.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_PEAK_FINDER_DEFINES_SVH
`define SPECTRAL_PEAK_FINDER_DEFINES_SVH

// Checked at every rising edge, masked while reset is high.
`define SPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/spf_pkg.sv
// ----------------------------------------------------------------------------
// Spectral peak finder package
// Shared constants and the job record passed from the front to the back.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int NUM_BINS_DEF  = 16384;
  localparam int MAX_PEAKS_DEF = 12;
  localparam int FRAC_BITS_DEF = 8;
  localparam int QUEUE_DEPTH   = 4;

  localparam int MAG_W   = 17;
  localparam int SUM_W   = 31;
  localparam int WSUM_W  = 45;
  localparam int BIN_F_W = 14;
  localparam int WID_F_W = 15;
  localparam int NUM_F_W = 4;
  localparam int CEN_F_W = 22;

  localparam logic KIND_PEAK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic CFG_ZERO_LEVEL = 1'b0;
  localparam logic CFG_PEAK_LEVEL = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [NUM_F_W-1:0] num;
    logic [BIN_F_W-1:0] start_bin;
    logic [BIN_F_W-1:0] end_bin;
    logic [WID_F_W-1:0] width;
    logic [SUM_W-1:0]   sum;
    logic [WSUM_W-1:0]  wsum;
    logic [MAG_W-1:0]   max;
    logic [NUM_F_W-1:0] count;
  } spf_job_t;

  typedef struct packed {
    logic     valid;
    spf_job_t job;
  } spf_push_t;

endpackage

FILE: hdl/spf_front.sv
// ----------------------------------------------------------------------------
// Spectral peak finder front end
// Classifies each bin, tracks the open peak and its sums, and decides which
// peaks are kept; kept peaks and summaries are pushed as jobs.
// ----------------------------------------------------------------------------
module spf_front #(
  parameter int NUM_BINS  = spf_pkg::NUM_BINS_DEF,
  parameter int MAX_PEAKS = spf_pkg::MAX_PEAKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [spf_pkg::MAG_W-1:0] cfg_data,
  input  logic                     take,
  input  logic [spf_pkg::MAG_W-1:0] magnitude,
  input  logic                     last_bin,
  output spf_pkg::spf_push_t       push_a,
  output spf_pkg::spf_push_t       push_b
);
  import spf_pkg::*;

  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int CNT_W  = $clog2(MAX_PEAKS + 1);
  localparam int PROD_W = BIN_W + MAG_W;

  logic [MAG_W-1:0]  zero_level;
  logic [MAG_W-1:0]  peak_level;
  logic              in_peak;
  logic [BIN_W-1:0]  bin_index;
  logic [BIN_W-1:0]  open_start;
  logic [BIN_W-1:0]  last_above_bin;
  logic [SUM_W-1:0]  running_sum;
  logic [WSUM_W-1:0] running_wsum;
  logic [SUM_W-1:0]  held_sum;
  logic [WSUM_W-1:0] held_wsum;
  logic [MAG_W-1:0]  running_max;
  logic [CNT_W-1:0]  kept_count;
  logic [BIN_W:0]    first_width;

  logic              active;
  logic              is_zero;
  logic              is_above;
  logic [PROD_W-1:0] prod;
  logic [SUM_W:0]    sum_ext;
  logic [WSUM_W:0]   wsum_ext;
  logic [SUM_W-1:0]  sum_acc;
  logic [WSUM_W-1:0] wsum_acc;
  logic [MAG_W-1:0]  max_acc;
  logic              closing;
  logic [BIN_W-1:0]  close_end;
  logic [SUM_W-1:0]  close_sum;
  logic [WSUM_W-1:0] close_wsum;
  logic [MAG_W-1:0]  close_max;
  logic [BIN_W:0]    close_width;
  logic              close_ok;
  logic              keep;
  logic [CNT_W-1:0]  count_next;

  assign active   = kept_count < CNT_W'(MAX_PEAKS);
  assign is_zero  = magnitude < zero_level;
  assign is_above = !is_zero && (magnitude >= peak_level);
  assign prod     = PROD_W'(bin_index) * PROD_W'(magnitude);
  assign sum_ext  = {1'b0, running_sum} + (SUM_W + 1)'(magnitude);
  assign wsum_ext = {1'b0, running_wsum} + (WSUM_W + 1)'(prod);
  assign sum_acc  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign wsum_acc = wsum_ext[WSUM_W] ? '1 : wsum_ext[WSUM_W-1:0];
  assign max_acc  = (magnitude > running_max) ? magnitude : running_max;

  always_comb begin
    closing = active && in_peak && is_zero;
    if (magnitude >= peak_level) begin
      close_end  = bin_index;
      close_sum  = sum_acc;
      close_wsum = wsum_acc;
      close_max  = max_acc;
    end else begin
      close_end  = last_above_bin;
      close_sum  = held_sum;
      close_wsum = held_wsum;
      close_max  = running_max;
    end
    close_width = {1'b0, close_end} - {1'b0, open_start} + (BIN_W + 1)'(1);
    close_ok    = (close_end >= open_start) && ((close_end - open_start) > BIN_W'(1));
    keep        = closing && close_ok &&
                  ((kept_count == '0) || ({1'b0, close_width} < {first_width, 1'b0}));
    count_next  = keep ? kept_count + CNT_W'(1) : kept_count;

    push_a.valid         = take && keep;
    push_a.job.kind      = KIND_PEAK;
    push_a.job.num       = NUM_F_W'(kept_count);
    push_a.job.start_bin = BIN_F_W'(open_start);
    push_a.job.end_bin   = BIN_F_W'(close_end);
    push_a.job.width     = WID_F_W'(close_width);
    push_a.job.sum       = close_sum;
    push_a.job.wsum      = close_wsum;
    push_a.job.max       = close_max;
    push_a.job.count     = '0;

    push_b.valid         = take && last_bin;
    push_b.job           = '0;
    push_b.job.kind      = KIND_SUMMARY;
    push_b.job.count     = NUM_F_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_level     <= MAG_W'(655);
      peak_level     <= MAG_W'(32768);
      in_peak        <= 1'b0;
      bin_index      <= '0;
      open_start     <= '0;
      last_above_bin <= '0;
      running_sum    <= '0;
      running_wsum   <= '0;
      held_sum       <= '0;
      held_wsum      <= '0;
      running_max    <= '0;
      kept_count     <= '0;
      first_width    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ZERO_LEVEL: zero_level <= cfg_data;
          CFG_PEAK_LEVEL: peak_level <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        if (last_bin) begin
          in_peak        <= 1'b0;
          bin_index      <= '0;
          open_start     <= '0;
          last_above_bin <= '0;
          running_sum    <= '0;
          running_wsum   <= '0;
          held_sum       <= '0;
          held_wsum      <= '0;
          running_max    <= '0;
          kept_count     <= '0;
          first_width    <= '0;
        end else begin
          if (bin_index < BIN_W'(NUM_BINS - 1)) begin
            bin_index <= bin_index + BIN_W'(1);
          end
          if (active) begin
            if (!in_peak) begin
              if (is_above) begin
                in_peak        <= 1'b1;
                open_start     <= bin_index;
                last_above_bin <= bin_index;
                running_sum    <= SUM_W'(magnitude);
                running_wsum   <= WSUM_W'(prod);
                held_sum       <= SUM_W'(magnitude);
                held_wsum      <= WSUM_W'(prod);
                running_max    <= magnitude;
              end
            end else if (!is_zero) begin
              running_sum  <= sum_acc;
              running_wsum <= wsum_acc;
              running_max  <= max_acc;
              if (is_above) begin
                last_above_bin <= bin_index;
                held_sum       <= sum_acc;
                held_wsum      <= wsum_acc;
              end
            end else begin
              in_peak    <= 1'b0;
              kept_count <= count_next;
              if (keep && (kept_count == '0)) begin
                first_width <= close_width;
              end
            end
          end
        end
      end
    end
  end

endmodule

FILE: hdl/spf_queue.sv
// ----------------------------------------------------------------------------
// Spectral peak finder job queue
// Short queue taking up to two jobs a cycle from the front and handing one
// job at a time to the back.
// ----------------------------------------------------------------------------
module spf_queue (
  input  logic               clk,
  input  logic               rst,
  input  spf_pkg::spf_push_t push_a,
  input  spf_pkg::spf_push_t push_b,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output spf_pkg::spf_job_t  head_job
);
  import spf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  spf_job_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W:0]   count;
  logic [PTR_W-1:0] tail_b;

  assign full     = count > (PTR_W + 1)'(QUEUE_DEPTH - 2);
  assign empty    = count == '0;
  assign head_job = entries[head];
  assign tail_b   = push_a.valid ? tail + PTR_W'(1) : tail;

  always_ff @(posedge clk) begin
    if (push_a.valid) begin
      entries[tail] <= push_a.job;
    end
    if (push_b.valid) begin
      entries[tail_b] <= push_b.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PTR_W'(push_a.valid) + PTR_W'(push_b.valid);
      head  <= head + PTR_W'(pop);
      count <= count + (PTR_W + 1)'(push_a.valid) + (PTR_W + 1)'(push_b.valid)
               - (PTR_W + 1)'(pop);
    end
  end

endmodule

FILE: hdl/spf_back.sv
// ----------------------------------------------------------------------------
// Spectral peak finder back end
// Takes one job at a time, works out the centroid with a bit-serial
// restoring divider and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module spf_back #(
  parameter int FRAC_BITS = spf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  spf_pkg::spf_job_t           head_job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        result_kind,
  output logic [spf_pkg::NUM_F_W-1:0] peak_number,
  output logic [spf_pkg::BIN_F_W-1:0] start_bin,
  output logic [spf_pkg::BIN_F_W-1:0] end_bin,
  output logic [spf_pkg::WID_F_W-1:0] peak_width,
  output logic [spf_pkg::CEN_F_W-1:0] centroid_bin,
  output logic [spf_pkg::MAG_W-1:0]   peak_max,
  output logic [spf_pkg::NUM_F_W-1:0] peak_count,
  output logic                        last
);
  import spf_pkg::*;

  localparam int NUM_W  = WSUM_W + FRAC_BITS;
  localparam int STEP_W = $clog2(NUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  spf_job_t          job;
  logic [NUM_W-1:0]  quot;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W:0]    rem_sh;
  logic [SUM_W:0]    diff;
  logic              ge;

  assign pop    = (state == ST_IDLE) && !empty;
  assign rem_sh = {rem, quot[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, job.sum};
  assign ge     = rem_sh >= {1'b0, job.sum};

  assign out_valid    = state == ST_OUT;
  assign result_kind  = job.kind;
  assign peak_number  = job.num;
  assign start_bin    = job.start_bin;
  assign end_bin      = job.end_bin;
  assign peak_width   = job.width;
  assign centroid_bin = quot[CEN_F_W-1:0];
  assign peak_max     = job.max;
  assign peak_count   = job.count;
  assign last         = job.kind == KIND_SUMMARY;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            step <= STEP_W'(NUM_W - 1);
            if ((head_job.kind == KIND_SUMMARY) || (head_job.sum == '0)) begin
              state <= ST_OUT;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          step <= step - STEP_W'(1);
          if (step == '0) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head_job;
      rem <= '0;
      if ((head_job.kind == KIND_SUMMARY) || (head_job.sum == '0)) begin
        quot <= '0;
      end else begin
        quot <= NUM_W'(head_job.wsum) << FRAC_BITS;
      end
    end else if (state == ST_DIV) begin
      quot <= {quot[NUM_W-2:0], ge};
      rem  <= ge ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
    end
  end

endmodule

FILE: hdl/spectral_peak_finder.sv
// A bin that closes a kept peak is pushed to the job queue; the back end pops the job
// when idle and shows the report once the one-bit-per-cycle centroid divider is done;
// a summary skips the divider. Throughput: one bin per cycle while the four-entry job
// queue has room for two jobs; the back end pops a job only once the last result is taken.
// Reset (rst, synchronous, active high) clears all peak state, empties the queue
// and loads zero_level 655 and peak_level 32768.
// ----------------------------------------------------------------------------
// Spectral peak finder
// Finds peaks in a stream of spectrum magnitudes and reports their extent,
// centroid and maximum, followed by a summary at the end of each spectrum.
// ----------------------------------------------------------------------------
module spectral_peak_finder #(
  parameter int NUM_BINS           = spf_pkg::NUM_BINS_DEF,
  parameter int MAX_PEAKS          = spf_pkg::MAX_PEAKS_DEF,
  parameter int CENTROID_FRAC_BITS = spf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [spf_pkg::MAG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spf_pkg::MAG_W-1:0]   magnitude,
  input  logic                        last_bin,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        result_kind,
  output logic [spf_pkg::NUM_F_W-1:0] peak_number,
  output logic [spf_pkg::BIN_F_W-1:0] start_bin,
  output logic [spf_pkg::BIN_F_W-1:0] end_bin,
  output logic [spf_pkg::WID_F_W-1:0] peak_width,
  output logic [spf_pkg::CEN_F_W-1:0] centroid_bin,
  output logic [spf_pkg::MAG_W-1:0]   peak_max,
  output logic [spf_pkg::NUM_F_W-1:0] peak_count,
  output logic                        last
);
  import spf_pkg::*;

  spf_push_t push_a;
  spf_push_t push_b;
  spf_job_t  head_job;
  logic      full;
  logic      empty;
  logic      pop;
  logic      take;

  assign in_stall = full;
  assign take     = in_valid && !full;

  spf_front #(
    .NUM_BINS  (NUM_BINS),
    .MAX_PEAKS (MAX_PEAKS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .magnitude (magnitude),
    .last_bin  (last_bin),
    .push_a    (push_a),
    .push_b    (push_b)
  );

  spf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_a   (push_a),
    .push_b   (push_b),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head_job (head_job)
  );

  spf_back #(
    .FRAC_BITS (CENTROID_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .peak_number  (peak_number),
    .start_bin    (start_bin),
    .end_bin      (end_bin),
    .peak_width   (peak_width),
    .centroid_bin (centroid_bin),
    .peak_max     (peak_max),
    .peak_count   (peak_count),
    .last         (last)
  );

endmodule

FILE: hdl/spf_checker.sv
// ----------------------------------------------------------------------------
// Spectral peak finder checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "spectral_peak_finder_defines.svh"

module spf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        result_kind,
  input logic [spf_pkg::NUM_F_W-1:0] peak_number,
  input logic [spf_pkg::WID_F_W-1:0] peak_width,
  input logic [spf_pkg::NUM_F_W-1:0] peak_count,
  input logic                        last
);
  import spf_pkg::*;

  `SPF_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result beat right after reset")
  `SPF_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(peak_width), "stalled beat dropped or changed")
  `SPF_ASSERT(a_summary_last, out_valid |-> (result_kind == last), "last flag does not match kind")
  `SPF_ASSERT(a_report_shape, out_valid && !result_kind |-> (peak_count == '0) && (peak_width > 15'd2), "bad peak report")
  `SPF_ASSERT(a_summary_zero, out_valid && result_kind |-> (peak_number == '0) && (peak_width == '0), "bad summary")

endmodule

bind spectral_peak_finder spf_checker u_spf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_kind (result_kind),
  .peak_number (peak_number),
  .peak_width  (peak_width),
  .peak_count  (peak_count),
  .last        (last)
);
